/* sv/vad_pkg.sv */
// Shared types, constants and the arctangent table for the angle pipeline.
// Used by vad_prep, vad_cell, vad_post and vector_angle_degrees.
// No dependencies.
package vad_pkg;

    // Defaults of the top-level parameters
    localparam int COORD_BITS_DEF      = 16;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;

    // Datapath widths: x/y are scaled so the difference sits near bit 59
    localparam int XY_W       = 64;
    localparam int SCALE_TOP  = 59;
    localparam int Z_W        = 36;
    localparam int ZFRAC      = 24;
    localparam int TABLE_LEN  = 24;
    localparam int TAB_IDX_W  = 5;

    // Angle accumulator values of 90 and 360 degrees
    localparam logic signed [Z_W-1:0] Z_DEG90 = Z_W'(90) <<< ZFRAC;
    localparam logic signed [Z_W-1:0] Z_DEG360 = Z_W'(360) <<< ZFRAC;

    // Axis-aligned and zero differences are answered without rotation
    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_90,
        SPEC_180,
        SPEC_270
    } spec_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   wrap;
        spec_t                  spec;
    } cordic_state_t;

    // atan(2^-i) in degrees with ZFRAC fraction bits
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(754974720);
            5'd1:    v = Z_W'(445687602);
            5'd2:    v = Z_W'(235489088);
            5'd3:    v = Z_W'(119537938);
            5'd4:    v = Z_W'(60000934);
            5'd5:    v = Z_W'(30029717);
            5'd6:    v = Z_W'(15018523);
            5'd7:    v = Z_W'(7509720);
            5'd8:    v = Z_W'(3754917);
            5'd9:    v = Z_W'(1877466);
            5'd10:   v = Z_W'(938734);
            5'd11:   v = Z_W'(469367);
            5'd12:   v = Z_W'(234684);
            5'd13:   v = Z_W'(117342);
            5'd14:   v = Z_W'(58671);
            5'd15:   v = Z_W'(29335);
            5'd16:   v = Z_W'(14668);
            5'd17:   v = Z_W'(7334);
            5'd18:   v = Z_W'(3667);
            5'd19:   v = Z_W'(1833);
            5'd20:   v = Z_W'(917);
            5'd21:   v = Z_W'(458);
            5'd22:   v = Z_W'(229);
            5'd23:   v = Z_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* sv/vector_angle_degrees.sv */
// Direction from one point to another in degrees, pipelined CORDIC arctangent.
// Registered stages: front stage, one cell per step, output stage.
// Throughput: one request per cycle while the output is not stalled; each stage holds
// its request only while the next stage is full and stalled, so input keeps flowing until every stage is occupied.
// Reset (aresetn low, synchronous) empties all stages; payload is not cleared.
// Depends on vad_pkg, vad_prep, vad_cell, vad_post.
module vector_angle_degrees #(
    parameter int COORD_BITS      = vad_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS    = vad_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = vad_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // from_x, from_y, to_x, to_y, wrap_positive, zero fill
    input  logic [((4*COORD_BITS+1+7)/8)*8-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // angle_deg, zero fill
    output logic [((ANGLE_FRAC_BITS+10+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W       = ANGLE_FRAC_BITS + 10;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam logic signed [OUT_W-1:0] ANG_MIN = -(OUT_W'(180) <<< ANGLE_FRAC_BITS);
    localparam logic signed [OUT_W-1:0] ANG_MAX =
        (OUT_W'(360) <<< ANGLE_FRAC_BITS) - OUT_W'(1);

    vad_pkg::cordic_state_t stage_data [0:CORDIC_STEPS];
    logic                   stage_valid [0:CORDIC_STEPS];
    logic                   stage_ready [0:CORDIC_STEPS];
    logic [OUT_W-1:0]       angle_deg;

    vad_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .from_x        (s_tdata[COORD_BITS-1:0]),
        .from_y        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .to_x          (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .to_y          (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .wrap_positive (s_tdata[4*COORD_BITS]),
        .out_valid     (stage_valid[0]),
        .out_ready     (stage_ready[0]),
        .out_data      (stage_data[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        vad_cell #(
            .STEP (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    vad_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid[CORDIC_STEPS]),
        .in_ready  (stage_ready[CORDIC_STEPS]),
        .in_data   (stage_data[CORDIC_STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .angle_deg (angle_deg)
    );

    assign m_tdata = OUT_TDATA_W'(angle_deg);

    // pipeline comes up empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // a free output slot must let ready reach the input
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with output free");

    // results stay inside the clamped angle range
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(angle_deg) >= ANG_MIN && $signed(angle_deg) <= ANG_MAX))
        else $error("angle out of range");

    // a stalled result is never replaced by an upstream request
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(angle_deg))
        else $error("stalled result changed");

endmodule

/* sv/vad_prep.sv */
// Front stage: point differences, axis cases and quadrant pre-rotation.
// Depends on vad_pkg.
module vad_prep #(
    parameter int COORD_BITS = vad_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COORD_BITS-1:0]     from_x,
    input  logic [COORD_BITS-1:0]     from_y,
    input  logic [COORD_BITS-1:0]     to_x,
    input  logic [COORD_BITS-1:0]     to_y,
    input  logic                      wrap_positive,
    output logic                      out_valid,
    input  logic                      out_ready,
    output vad_pkg::cordic_state_t    out_data
);

    localparam int SCALE_SHIFT = vad_pkg::SCALE_TOP - COORD_BITS;

    logic signed [COORD_BITS:0]         dx;
    logic signed [COORD_BITS:0]         dy;
    logic signed [vad_pkg::XY_W-1:0]    xs;
    logic signed [vad_pkg::XY_W-1:0]    ys;
    vad_pkg::cordic_state_t             data_next;
    vad_pkg::cordic_state_t             data_reg;
    logic                               valid_reg;
    logic                               valid_next;

    always_comb begin
        dx = $signed({to_x[COORD_BITS-1], to_x}) - $signed({from_x[COORD_BITS-1], from_x});
        dy = $signed({to_y[COORD_BITS-1], to_y}) - $signed({from_y[COORD_BITS-1], from_y});
        xs = vad_pkg::XY_W'(dx) <<< SCALE_SHIFT;
        ys = vad_pkg::XY_W'(dy) <<< SCALE_SHIFT;

        data_next.wrap = wrap_positive;
        if (dx == '0 && dy == '0) begin
            data_next.spec = vad_pkg::SPEC_ZERO;
        end else if (dx == '0) begin
            data_next.spec = (dy < 0) ? vad_pkg::SPEC_270 : vad_pkg::SPEC_90;
        end else if (dy == '0) begin
            data_next.spec = (dx < 0) ? vad_pkg::SPEC_180 : vad_pkg::SPEC_ZERO;
        end else begin
            data_next.spec = vad_pkg::SPEC_NONE;
        end

        // left half-plane: turn by a quarter so the rotation converges
        if (dx < 0) begin
            if (dy > 0) begin
                data_next.x = ys;
                data_next.y = -xs;
                data_next.z = vad_pkg::Z_DEG90;
            end else begin
                data_next.x = -ys;
                data_next.y = xs;
                data_next.z = -vad_pkg::Z_DEG90;
            end
        end else begin
            data_next.x = xs;
            data_next.y = ys;
            data_next.z = '0;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/vad_cell.sv */
// One vectoring rotation step of the arctangent chain.
// Depends on vad_pkg.
module vad_cell #(
    parameter int STEP = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vad_pkg::cordic_state_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vad_pkg::cordic_state_t out_data
);

    logic signed [vad_pkg::XY_W-1:0] x_sh;
    logic signed [vad_pkg::XY_W-1:0] y_sh;
    logic signed [vad_pkg::Z_W-1:0]  step_ang;
    vad_pkg::cordic_state_t          data_next;
    vad_pkg::cordic_state_t          data_reg;
    logic                            valid_reg;
    logic                            valid_next;

    always_comb begin
        x_sh     = $signed(in_data.x) >>> STEP;
        y_sh     = $signed(in_data.y) >>> STEP;
        step_ang = vad_pkg::atan_deg(vad_pkg::TAB_IDX_W'(STEP));
        data_next      = in_data;
        if ($signed(in_data.y) > 0) begin
            data_next.x = in_data.x + y_sh;
            data_next.y = in_data.y - x_sh;
            data_next.z = in_data.z + step_ang;
        end else begin
            data_next.x = in_data.x - y_sh;
            data_next.y = in_data.y + x_sh;
            data_next.z = in_data.z - step_ang;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/vad_post.sv */
// Last stage: wrap, round to the output fraction, clamp, and axis-case select.
// Holds the output register. Depends on vad_pkg.
module vad_post #(
    parameter int ANGLE_FRAC_BITS = vad_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  vad_pkg::cordic_state_t      in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ANGLE_FRAC_BITS+9:0]  angle_deg
);

    localparam int OUT_W = ANGLE_FRAC_BITS + 10;
    localparam int RSH   = vad_pkg::ZFRAC - ANGLE_FRAC_BITS;
    localparam logic signed [vad_pkg::Z_W-1:0] HALF = vad_pkg::Z_W'(1) <<< (RSH - 1);
    localparam logic signed [vad_pkg::Z_W-1:0] WRAP_HALF = vad_pkg::Z_DEG360 + HALF;
    localparam logic signed [vad_pkg::Z_W-1:0] LO = -(vad_pkg::Z_W'(180) <<< ANGLE_FRAC_BITS);
    localparam logic signed [vad_pkg::Z_W-1:0] HI =
        (vad_pkg::Z_W'(360) <<< ANGLE_FRAC_BITS) - vad_pkg::Z_W'(1);
    localparam logic signed [OUT_W-1:0] ANG90  = OUT_W'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [OUT_W-1:0] ANG180 = OUT_W'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [OUT_W-1:0] ANG270 = OUT_W'(270) <<< ANGLE_FRAC_BITS;

    logic signed [vad_pkg::Z_W-1:0] z_biased;
    logic signed [vad_pkg::Z_W-1:0] z_round;
    logic signed [OUT_W-1:0]        angle_next;
    logic signed [OUT_W-1:0]        angle_reg;
    logic                           valid_reg;
    logic                           valid_next;

    always_comb begin
        // wrap offset and rounding half folded into one add
        if (in_data.wrap && in_data.z < 0) begin
            z_biased = in_data.z + WRAP_HALF;
        end else begin
            z_biased = in_data.z + HALF;
        end
        z_round = z_biased >>> RSH;

        case (in_data.spec)
            vad_pkg::SPEC_ZERO: angle_next = '0;
            vad_pkg::SPEC_90:   angle_next = ANG90;
            vad_pkg::SPEC_180:  angle_next = ANG180;
            vad_pkg::SPEC_270:  angle_next = ANG270;
            default: begin
                if (z_round > HI) begin
                    angle_next = OUT_W'(HI);
                end else if (z_round < LO) begin
                    angle_next = OUT_W'(LO);
                end else begin
                    angle_next = OUT_W'(z_round);
                end
            end
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign angle_deg = angle_reg;

endmodule
